// File: rtl/core/fau_pkg.sv
// fau_pkg: shared types and codes for the fraction arithmetic unit
// no dependencies
`timescale 1ns / 1ps

package fau_pkg;

   localparam int InWidth  = 16;
   localparam int NumWidth = 33;
   localparam int DenWidth = 32;

   // operation codes
   localparam logic [2:0] ACT_REDUCE = 3'd0;
   localparam logic [2:0] ACT_ADD    = 3'd1;
   localparam logic [2:0] ACT_SUB    = 3'd2;
   localparam logic [2:0] ACT_MUL    = 3'd3;
   localparam logic [2:0] ACT_DIV    = 3'd4;

   typedef struct packed {
      logic [2:0]                 action;
      logic signed [InWidth-1:0]  num_first;
      logic signed [InWidth-1:0]  den_first;
      logic signed [InWidth-1:0]  num_second;
      logic signed [InWidth-1:0]  den_second;
   } req_type;

   typedef struct packed {
      logic signed [NumWidth-1:0] res_num;
      logic [DenWidth-1:0]        res_den;
      logic                       err_flag;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;     // capture beat, form products
      logic mags;     // form magnitudes from products
      logic div_start;
      logic div_sel;  // 0: gcd step a%b, 1: final quotient
      logic gcd_step; // shift a<=b, b<=rem
      logic q_num;    // quotient into num
      logic q_den;    // quotient into den
      logic finish;   // build result
   } fau_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic err;      // operation invalid
      logic zero;     // zero numerator
      logic b_zero;   // gcd finished
      logic div_busy;
   } fau_sts_type;

endpackage

// File: rtl/core/fau_datapath.sv
// fau_datapath: products, magnitudes, shared restoring divider, result register
// depends on fau_pkg
`timescale 1ns / 1ps

module fau_datapath #(
   parameter int IN_WIDTH = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [2:0]                action,
   input  logic [4*IN_WIDTH-1:0]     operands,
   input  fau_pkg::fau_cmd_type      cmd,
   output fau_pkg::fau_sts_type      sts,
   output fau_pkg::rsp_type          result
);
   import fau_pkg::*;

   localparam int PW = 2 * IN_WIDTH + 1;   // signed product / sum width
   localparam int MW = 2 * IN_WIDTH + 1;   // magnitude width
   localparam int CW = $clog2(MW + 1);

   logic signed [IN_WIDTH-1:0] na, da, nb, db;
   logic signed [PW-1:0] pd_ff, pn_in, pd_in;
   logic signed [PW-1:0] t0_ff, t1_ff;
   logic [2:0]   act_ff;
   logic         err_ff, err_in, neg_ff;
   logic [MW-1:0] mn_ff, md_ff, ga_ff, gb_ff;
   // divider
   logic [MW-1:0] dq_ff, dr_ff, dd_ff;
   logic [CW-1:0] dcnt_ff;
   logic          dbusy_ff;
   logic [MW:0]   trial;
   logic [MW-1:0] rsh;
   rsp_type       res_ff;

   assign {na, da, nb, db} = operands;

   function automatic logic [MW-1:0] mag(input logic signed [PW-1:0] v);
      logic signed [PW-1:0] t;
      t = v[PW-1] ? -v : v;
      return MW'(t);
   endfunction

   // products are registered before combining
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff <= action;
         unique case (action)
            ACT_ADD, ACT_SUB: begin
               t0_ff <= PW'(na * db);
               t1_ff <= PW'(nb * da);
               pd_ff <= PW'(da * db);
            end
            ACT_MUL: begin
               t0_ff <= PW'(na * nb);
               t1_ff <= '0;
               pd_ff <= PW'(da * db);
            end
            ACT_DIV: begin
               t0_ff <= PW'(na * db);
               t1_ff <= '0;
               pd_ff <= PW'(da * nb);
            end
            default: begin
               t0_ff <= PW'(na);
               t1_ff <= '0;
               pd_ff <= PW'(da);
            end
         endcase
         err_ff <= err_in;
      end
   end

   always_comb begin
      err_in = 1'b0;
      if (action == ACT_REDUCE) err_in = (da == '0);
      else if (action > ACT_DIV || da == '0 || db == '0) err_in = 1'b1;
      else if (action == ACT_DIV && nb == '0) err_in = 1'b1;
   end

   always_comb begin
      pn_in = (act_ff == ACT_SUB) ? t0_ff - t1_ff : t0_ff + t1_ff;
      pd_in = pd_ff;
   end

   // magnitudes and sign
   always_ff @(posedge clock) begin
      if (cmd.mags) begin
         mn_ff  <= mag(pn_in);
         md_ff  <= mag(pd_in);
         ga_ff  <= mag(pn_in);
         gb_ff  <= mag(pd_in);
         neg_ff <= pn_in[PW-1] ^ pd_in[PW-1];
      end else if (cmd.gcd_step) begin
         ga_ff <= gb_ff;
         gb_ff <= dr_ff;
      end else if (!cmd.div_start) begin
         if (cmd.q_num) mn_ff <= dq_ff;
         if (cmd.q_den) md_ff <= dq_ff;
      end
   end

   // restoring divider, one quotient bit per cycle
   assign rsh   = {dr_ff[MW-2:0], dq_ff[MW-1]};
   assign trial = {1'b0, rsh} - {1'b0, dd_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         dbusy_ff <= 1'b0;
         dcnt_ff  <= '0;
      end else if (cmd.div_start) begin
         dbusy_ff <= 1'b1;
         dcnt_ff  <= CW'(MW);
         dr_ff    <= '0;
         if (cmd.div_sel) begin
            dq_ff <= cmd.q_num ? mn_ff : md_ff;
            dd_ff <= ga_ff;
         end else begin
            dq_ff <= ga_ff;
            dd_ff <= gb_ff;
         end
      end else if (dbusy_ff) begin
         if (trial[MW]) begin
            dr_ff <= rsh;
            dq_ff <= {dq_ff[MW-2:0], 1'b0};
         end else begin
            dr_ff <= trial[MW-1:0];
            dq_ff <= {dq_ff[MW-2:0], 1'b1};
         end
         dcnt_ff <= dcnt_ff - CW'(1);
         if (dcnt_ff == CW'(1)) dbusy_ff <= 1'b0;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         if (err_ff) begin
            res_ff <= '{res_num: '0, res_den: DenWidth'(1), err_flag: 1'b1};
         end else if (mn_ff == '0) begin
            res_ff <= '{res_num: '0, res_den: DenWidth'(1), err_flag: 1'b0};
         end else begin
            res_ff.res_num  <= neg_ff ? -NumWidth'(mn_ff) : NumWidth'(mn_ff);
            res_ff.res_den  <= DenWidth'(md_ff);
            res_ff.err_flag <= 1'b0;
         end
      end
   end

   assign sts.err      = err_ff;
   assign sts.zero     = (mn_ff == '0);
   assign sts.b_zero   = (gb_ff == '0);
   assign sts.div_busy = dbusy_ff;
   assign result       = res_ff;

   // divider never restarts while running
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      dbusy_ff |-> !cmd.div_start) else $error("divider restarted");
   a_cnt_busy: assert property (@(posedge clock) disable iff (reset)
      !dbusy_ff |-> dcnt_ff == '0) else $error("divider count stale");
   a_ok_den: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.finish) && !res_ff.err_flag |-> res_ff.res_den != '0)
      else $error("zero denominator");

endmodule

// File: rtl/core/fau_ctrl.sv
// fau_ctrl: sequencer for the gcd loop and the two final divisions
// depends on fau_pkg
`timescale 1ns / 1ps

module fau_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  fau_pkg::fau_sts_type sts,
   output fau_pkg::fau_cmd_type cmd
);
   import fau_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_COMB  = 4'd1;
   localparam logic [3:0] S_CHECK = 4'd2;
   localparam logic [3:0] S_GWAIT = 4'd3;
   localparam logic [3:0] S_NDIV  = 4'd4;
   localparam logic [3:0] S_NWAIT = 4'd5;
   localparam logic [3:0] S_DDIV  = 4'd6;
   localparam logic [3:0] S_DWAIT = 4'd7;
   localparam logic [3:0] S_FIN   = 4'd8;
   localparam logic [3:0] S_GSTEP = 4'd9;

   logic [3:0] state_ff, state_in;
   logic       out_ff, out_in;
   logic       accept;

   // one item in flight; the result register frees once its beat is taken
   assign req_ready = (state_ff == S_IDLE) && !out_ff;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = out_ff;

   always_comb begin
      state_in = state_ff;
      out_in   = out_ff && !rsp_ready;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: if (accept) begin
            cmd.load = 1'b1;
            state_in = S_COMB;
         end
         S_COMB: begin
            cmd.mags = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (sts.err || sts.zero) state_in = S_FIN;
            else if (sts.b_zero) state_in = S_NDIV;
            else begin
               cmd.div_start = 1'b1;
               state_in = S_GWAIT;
            end
         end
         S_GWAIT: if (!sts.div_busy) state_in = S_GSTEP;
         S_GSTEP: begin
            cmd.gcd_step = 1'b1;
            state_in = S_CHECK;
         end
         S_NDIV: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = 1'b1;
            cmd.q_num     = 1'b1;
            state_in = S_NWAIT;
         end
         S_NWAIT: if (!sts.div_busy) begin
            cmd.q_num = 1'b1;
            state_in = S_DDIV;
         end
         S_DDIV: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = 1'b1;
            state_in = S_DWAIT;
         end
         S_DWAIT: if (!sts.div_busy) begin
            cmd.q_den = 1'b1;
            state_in = S_FIN;
         end
         S_FIN: begin
            cmd.finish = 1'b1;
            out_in   = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         out_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_ff   <= out_in;
      end
   end

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !req_ready) else $error("accept while busy");
   a_fin_out: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FIN |=> rsp_valid) else $error("result not shown");
   a_fin_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FIN |-> !out_ff) else $error("result overwritten");

endmodule

// File: rtl/core/fraction_arithmetic_unit.sv
// fraction_arithmetic_unit: top level, joins controller and datapath
// depends on fau_pkg, fau_ctrl, fau_datapath
`timescale 1ns / 1ps
//
// usage
// - req channel: one beat carries an action code and two signed fractions
// - rsp channel: one beat per request with the reduced numerator, the
//   positive denominator and an error flag (error results read 0/1)
// - one request in work at a time; ready is low from accept until the
//   result beat has been taken, and rises again the cycle after that
// - each modulo of the euclid loop and each final quotient runs on one
//   shared restoring divider giving one bit per cycle
// - reset clears the sequencer and drops any pending result
// - a stalled rsp beat holds its payload; no new request is taken until it
//   leaves
//
module fraction_arithmetic_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  fau_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output fau_pkg::rsp_type  rsp_data
);
   import fau_pkg::*;

   fau_cmd_type cmd;
   fau_sts_type sts;

   fau_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .sts, .cmd
   );

   fau_datapath #(.IN_WIDTH(InWidth)) u_dp (
      .clock, .reset,
      .action   (req_data.action),
      .operands ({req_data.num_first, req_data.den_first,
                  req_data.num_second, req_data.den_second}),
      .cmd, .sts,
      .result   (rsp_data)
   );

endmodule

// File: tb/tb.sv
// tb: self-checking bench for fraction_arithmetic_unit, rational ops with gcd reduction
// depends on fau_pkg and the fraction_arithmetic_unit rtl
`timescale 1ns / 1ps

module tb;
   import fau_pkg::*;

   // expected reduced fractions, one per accepted request
   class fraction_scoreboard;
      rsp_type pending_q[$];
      int      mismatches;
      int      checked;

      // reduce num/den by the gcd of magnitudes, sign on numerator
      function rsp_type reduce_fraction(longint num, longint den);
         rsp_type r;
         longint unsigned mn, md, x, y, t;
         bit neg;
         r.err_flag = 1'b0;
         if (num == 0) begin
            r.res_num = '0;
            r.res_den = 32'd1;
            return r;
         end
         neg = (num < 0) != (den < 0);
         mn = (num < 0) ? -num : num;
         md = (den < 0) ? -den : den;
         x = mn;
         y = md;
         while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
         end
         mn = mn / x;
         md = md / x;
         if (neg) mn = -mn;
         r.res_num = mn[32:0];
         r.res_den = md[31:0];
         return r;
      endfunction

      function rsp_type compute_result(req_type q);
         rsp_type err;
         longint na, da, nb, db;
         err.res_num = '0;
         err.res_den = 32'd1;
         err.err_flag = 1'b1;
         na = q.num_first;
         da = q.den_first;
         nb = q.num_second;
         db = q.den_second;
         if (q.action == ACT_REDUCE) begin
            if (da == 0) return err;
            return reduce_fraction(na, da);
         end
         if (q.action > ACT_DIV || da == 0 || db == 0) return err;
         case (q.action)
            ACT_ADD: return reduce_fraction(na * db + nb * da, da * db);
            ACT_SUB: return reduce_fraction(na * db - nb * da, da * db);
            ACT_MUL: return reduce_fraction(na * nb, da * db);
            default: begin
               if (nb == 0) return err;
               return reduce_fraction(na * db, da * nb);
            end
         endcase
      endfunction

      function void note_request(req_type q);
         pending_q.push_back(compute_result(q));
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         checked++;
         if (pending_q.size() == 0) begin
            report_mismatch("result beat with nothing expected");
            return;
         end
         want = pending_q.pop_front();
         if (got.res_num !== want.res_num)
            report_mismatch($sformatf("res_num got %0d want %0d", got.res_num, want.res_num));
         if (got.res_den !== want.res_den)
            report_mismatch($sformatf("res_den got %0d want %0d", got.res_den, want.res_den));
         if (got.err_flag !== want.err_flag)
            report_mismatch($sformatf("err_flag got %0b want %0b",
                                      got.err_flag, want.err_flag));
      endfunction

      function void report_mismatch(string msg);
         mismatches++;
         if (mismatches <= 50) $display("tb: mismatch at %0t: %s", $realtime, msg);
      endfunction
   endclass

   localparam int NumRandom = 2000;
   localparam longint CycleLimit = 64'd20_000_000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   fraction_scoreboard fractions = new();
   longint cycle_count;
   bit     hold_off;      // long receiver stall
   bit     calm_stretch;  // no idling on either side
   int     error_results;

   fraction_arithmetic_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("tb: failure");
         $finish;
      end
   end

   // accept monitor for both channels
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) fractions.note_request(req_data);
      if (!reset && rsp_valid && rsp_ready) begin
         if (rsp_data.err_flag) error_results <= error_results + 1;
         fractions.check_result(rsp_data);
      end
   end

   // receiver: random stalls, held off while hold_off is set
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else if (hold_off) rsp_ready <= 1'b0;
      else if (calm_stretch) rsp_ready <= 1'b1;
      else rsp_ready <= ($urandom_range(99) >= 22);
   end

   // long receiver hold-off, counted in its own process
   initial begin
      hold_off = 1'b0;
      while (fractions.checked < 400) @(posedge clock);
      hold_off <= 1'b1;
      repeat (3000) @(posedge clock);
      hold_off <= 1'b0;
   end

   function automatic logic signed [InWidth-1:0] pick_value();
      case ($urandom_range(9))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return '0;
         3: return 16'sd1;
         4: return -16'sd1;
         5, 6: return InWidth'($urandom);
         default: return $signed(16'($urandom_range(40))) - 16'sd20;
      endcase
   endfunction

   // one request beat, with optional random idle before it
   task automatic send_request(req_type q);
      if (!calm_stretch) begin
         while ($urandom_range(99) < 22) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data  <= q;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_fraction_op(logic [2:0] op, logic signed [15:0] a, logic signed [15:0] b,
                                   logic signed [15:0] c, logic signed [15:0] d);
      req_type q;
      q.action = op;
      q.num_first = a;
      q.den_first = b;
      q.num_second = c;
      q.den_second = d;
      send_request(q);
   endtask

   initial begin
      req_type q;
      int      unused_op;
      req_valid = 1'b0;
      req_data  = '0;
      cycle_count = 0;
      error_results = 0;
      calm_stretch = 1'b0;
      reset = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, each operation, unused codes, error and zero cases
      send_fraction_op(ACT_REDUCE, 16'sd6, -16'sd4, 16'sd0, 16'sd1);
      send_fraction_op(ACT_REDUCE, 16'sd5, 16'sd0, 16'sd1, 16'sd1);
      send_fraction_op(ACT_REDUCE, 16'sd0, -16'sd7, 16'sd0, 16'sd0);
      send_fraction_op(ACT_REDUCE, 16'sh8000, 16'sh8000, 16'sd3, 16'sd0);
      send_fraction_op(ACT_REDUCE, 16'sh7fff, 16'sh8000, 16'sd0, 16'sd0);
      send_fraction_op(ACT_ADD, 16'sd1, 16'sd2, 16'sd1, 16'sd3);
      send_fraction_op(ACT_ADD, 16'sd1, 16'sd2, -16'sd1, 16'sd2);
      send_fraction_op(ACT_ADD, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7ffe);
      send_fraction_op(ACT_ADD, 16'sd1, 16'sd2, 16'sd1, 16'sd0);
      send_fraction_op(ACT_SUB, 16'sd3, 16'sd4, 16'sd1, 16'sd4);
      send_fraction_op(ACT_SUB, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
      send_fraction_op(ACT_SUB, 16'sd1, 16'sd0, 16'sd1, 16'sd1);
      send_fraction_op(ACT_MUL, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
      send_fraction_op(ACT_MUL, 16'sh8000, 16'sd1, 16'sh8000, 16'sd1);
      send_fraction_op(ACT_MUL, 16'sd0, 16'sd5, 16'sd9, -16'sd3);
      send_fraction_op(ACT_DIV, 16'sd2, 16'sd3, -16'sd4, 16'sd9);
      send_fraction_op(ACT_DIV, 16'sd2, 16'sd3, 16'sd0, 16'sd9);
      send_fraction_op(ACT_DIV, 16'sh8000, 16'sd1, 16'sd1, 16'sh8000);
      send_fraction_op(ACT_DIV, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
      for (unused_op = 5; unused_op < 8; unused_op++)
         send_fraction_op(3'(unused_op), 16'sd1, 16'sd2, 16'sd3, 16'sd4);

      // random requests; a middle stretch runs with no idling
      for (int n = 0; n < NumRandom; n++) begin
         calm_stretch = (n >= 1200 && n < 1400);
         q.action = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5))
                                              : 3'($urandom_range(4));
         q.num_first  = pick_value();
         q.den_first  = pick_value();
         q.num_second = pick_value();
         q.den_second = pick_value();
         send_request(q);
      end
      calm_stretch = 1'b0;
      req_valid <= 1'b0;

      // drain
      while (fractions.pending_q.size() != 0) @(posedge clock);
      repeat (1200) @(posedge clock);

      $display("tb: %0d results checked, %0d of them error results",
               fractions.checked, error_results);
      $display("tb: all five operations, unused codes, zero denominators and extremes driven");
      if (fractions.mismatches == 0 && fractions.pending_q.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
